[design/jgd_pkg.sv]
`default_nettype none

package jgd_pkg;

    // Field widths
    localparam int unsigned SY_W = 12;
    localparam int unsigned SM_W = 4;
    localparam int unsigned SD_W = 5;
    localparam int unsigned GY_W = 13;
    localparam int unsigned GM_W = 4;
    localparam int unsigned GD_W = 5;

    // Internal widths
    localparam int unsigned DAYS_W = 21;   // full day count
    localparam int unsigned D400_W = 18;   // day within a 400-year period
    localparam int unsigned D100_W = 16;   // day within a century
    localparam int unsigned D4_W   = 11;   // day within a 4-year period
    localparam int unsigned DOY_W  = 9;    // day of year

    // Calendar constants
    localparam logic [SY_W-1:0]   JALALI_REBASE = 12'd979;
    localparam logic [GY_W-1:0]   GREG_BASE_HI  = 13'd1600;
    localparam logic [GY_W-1:0]   GREG_BASE_LO  = 13'd621;
    localparam logic [D400_W-1:0] DAYS_400Y     = 18'd146097;
    localparam logic [D100_W-1:0] DAYS_100Y     = 16'd36524;
    localparam logic [D4_W-1:0]   DAYS_4Y       = 11'd1461;
    localparam logic [DOY_W-1:0]  DAYS_1Y       = 9'd365;
    localparam logic [DOY_W-1:0]  NEW_YEAR_OFS  = 9'd78;
    localparam logic [DOY_W-1:0]  FIRST_HALF    = 9'd186;

    localparam int unsigned Q400_MAX = 7;
    localparam int unsigned Q100_MAX = 3;
    localparam int unsigned Q1Y_MAX  = 3;

    // Reciprocals for constant division: q = (x * RECIP) >> SHIFT
    localparam logic [10:0] RECIP_33    = 11'd1986;
    localparam int unsigned SHIFT_33    = 16;
    localparam logic [15:0] RECIP_1461  = 16'd45934;
    localparam int unsigned SHIFT_1461  = 26;
    localparam logic [13:0] RECIP_25    = 14'd10486;
    localparam int unsigned SHIFT_25    = 18;

    // Last day of each month in a common year
    localparam logic [DOY_W-1:0] MONTH_END [12] = '{
        9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };

    // Days before the Jalali month plus the new-year offset; month 0 wraps
    // to minus one month and months above 12 keep counting at 30 days.
    function automatic logic [DOY_W-1:0] month_base(input logic [SM_W-1:0] jm);
        logic [DOY_W-1:0] m;
        m = DOY_W'(jm);
        if (jm < SM_W'(7))
        begin
            return NEW_YEAR_OFS + DOY_W'(31) * m - DOY_W'(31);
        end
        else
        begin
            return NEW_YEAR_OFS + FIRST_HALF + DOY_W'(30) * (m - DOY_W'(7));
        end
    endfunction

endpackage

`default_nettype wire

[design/jgd_channels.sv]
`default_nettype none

interface jgd_solar_if import jgd_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [SY_W-1:0] solar_year;
    logic [SM_W-1:0] solar_month;
    logic [SD_W-1:0] solar_day;

    modport source (output valid, output solar_year, output solar_month,
                    output solar_day, input ready);
    modport sink   (input valid, input solar_year, input solar_month,
                    input solar_day, output ready);
endinterface

interface jgd_greg_if import jgd_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [GY_W-1:0] greg_year;
    logic [GM_W-1:0] greg_month;
    logic [GD_W-1:0] greg_day;

    modport source (output valid, output greg_year, output greg_month,
                    output greg_day, input ready);
    modport sink   (input valid, input greg_year, input greg_month,
                    input greg_day, output ready);
endinterface

`default_nettype wire

[design/jalali_to_gregorian_date.sv]
`default_nettype none

// Jalali to Gregorian date converter. One date word enters on the solar channel
// and exactly one Gregorian date word leaves on the greg channel, in order. The
// block is an 11-stage pipeline: it accepts a new word every cycle unless the
// ready chain holds stage 1. Throughput is set by the ready chain through the
// stages; a stalled output holds each full stage with no empty stage after it,
// and the stages ahead of an empty one keep moving. Divisions by calendar
// constants are done by compare ladders and reciprocal multipliers, each in its
// own stage. Inputs are not range checked: month 0, months 13 to 15 and day 0
// follow the same arithmetic, and a day number past the end of the Gregorian
// year gives month 13 with the leftover day count. No state is kept between words.
module jalali_to_gregorian_date import jgd_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    jgd_solar_if.sink   solar,
    jgd_greg_if.source  greg
);

    localparam int unsigned NSTG = 11;

    logic [NSTG-1:0] adv;
    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] valid_next;

    // Stage 1: rebase year, month offset
    logic              s1_hi_reg,  s1_hi_next;
    logic [SY_W-1:0]   s1_jy_reg,  s1_jy_next;
    logic [DOY_W-1:0]  s1_cm_reg,  s1_cm_next;
    logic [SD_W-1:0]   s1_jd_reg;

    // Stage 2: year / 33
    logic              s2_hi_reg;
    logic [SY_W-1:0]   s2_jy_reg;
    logic [6:0]        s2_q33_reg, s2_q33_next;
    logic [DOY_W-1:0]  s2_cm_reg;
    logic [SD_W-1:0]   s2_jd_reg;
    logic [22:0]       s2_prod;

    // Stage 3: partial day count
    logic              s3_hi_reg;
    logic [5:0]        s3_r33_reg, s3_r33_next;
    logic [DAYS_W-1:0] s3_p_reg,   s3_p_next;
    logic [SY_W-1:0]   s3_m33;

    // Stage 4: full day count
    logic              s4_hi_reg;
    logic [DAYS_W-1:0] s4_days_reg, s4_days_next;

    // Stage 5: 400-year periods
    logic              s5_hi_reg;
    logic [2:0]        s5_q400_reg, s5_q400_next;
    logic [D400_W-1:0] s5_d1_reg,   s5_d1_next;

    // Stage 6: centuries
    logic              s6_hi_reg;
    logic [2:0]        s6_q400_reg;
    logic              s6_cent_reg, s6_cent_next;
    logic [1:0]        s6_q100_reg, s6_q100_next;
    logic [D100_W-1:0] s6_d2_reg,   s6_d2_next;

    // Stage 7: century fix-up, 4-year periods
    logic              s7_hi_reg;
    logic [2:0]        s7_q400_reg;
    logic [1:0]        s7_q100_reg;
    logic [D100_W-1:0] s7_d3_reg,   s7_d3_next;
    logic [4:0]        s7_q4y_reg,  s7_q4y_next;
    logic [31:0]       s7_prod;

    // Stage 8: day within 4-year period
    logic              s8_hi_reg;
    logic [2:0]        s8_q400_reg;
    logic [1:0]        s8_q100_reg;
    logic [4:0]        s8_q4y_reg;
    logic [D4_W-1:0]   s8_r_reg,    s8_r_next;

    // Stage 9: single years, Gregorian year
    logic [GY_W-1:0]   s9_gy_reg,   s9_gy_next;
    logic [DOY_W-1:0]  s9_dd_reg,   s9_dd_next;
    logic [1:0]        s9_y1;

    // Stage 10: year / 25 for the leap rule
    logic [GY_W-1:0]   s10_gy_reg;
    logic [8:0]        s10_q25_reg, s10_q25_next;
    logic [DOY_W-1:0]  s10_gd_reg,  s10_gd_next;
    logic [26:0]       s10_prod;

    // Stage 11: leap rule, month and day
    logic [GY_W-1:0]   out_year_reg;
    logic [GM_W-1:0]   out_month_reg, out_month_next;
    logic [GD_W-1:0]   out_day_reg,   out_day_next;
    logic [4:0]        s11_rem25;
    logic              s11_leap;
    logic [DOY_W-1:0]  s11_thr [12];
    logic [11:0]       s11_above;
    logic [3:0]        s11_cnt;
    logic [DOY_W-1:0]  s11_prior;

    // Handshake: a stage advances when it is empty or its successor advances
    always_comb
    begin
        adv[NSTG-1] = !valid_reg[NSTG-1] || greg.ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (adv[0])
        begin
            valid_next[0] = solar.valid;
        end
        for (int k = 1; k < NSTG; k++)
        begin
            if (adv[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign solar.ready     = adv[0];
    assign greg.valid      = valid_reg[NSTG-1];
    assign greg.greg_year  = out_year_reg;
    assign greg.greg_month = out_month_reg;
    assign greg.greg_day   = out_day_reg;

    // Stage 1
    always_comb
    begin
        s1_hi_next = solar.solar_year > JALALI_REBASE;
        s1_jy_next = s1_hi_next ? (solar.solar_year - JALALI_REBASE) : solar.solar_year;
        s1_cm_next = month_base(solar.solar_month);
    end

    // Stage 2
    always_comb
    begin
        s2_prod     = 23'(s1_jy_reg) * 23'(RECIP_33);
        s2_q33_next = s2_prod[22:SHIFT_33];
    end

    // Stage 3
    always_comb
    begin
        s3_m33      = SY_W'(s2_q33_reg) * SY_W'(33);
        s3_r33_next = 6'(s2_jy_reg - s3_m33);
        s3_p_next   = DAYS_W'(s2_jy_reg) * DAYS_W'(DAYS_1Y)
                    + (DAYS_W'(s2_q33_reg) << 3)
                    + DAYS_W'(s2_cm_reg)
                    + DAYS_W'(s2_jd_reg);
    end

    // Stage 4
    always_comb
    begin
        s4_days_next = s3_p_reg + DAYS_W'((7'(s3_r33_reg) + 7'd3) >> 2);
    end

    // Stage 5
    always_comb
    begin
        s5_q400_next = '0;
        for (int k = 1; k <= Q400_MAX; k++)
        begin
            if (s4_days_reg >= DAYS_W'(k) * DAYS_W'(DAYS_400Y))
            begin
                s5_q400_next = 3'(k);
            end
        end
        s5_d1_next = D400_W'(s4_days_reg - DAYS_W'(s5_q400_next) * DAYS_W'(DAYS_400Y));
    end

    // Stage 6: drop the extra day of the first century
    always_comb
    begin
        s6_cent_next = s5_d1_reg > D400_W'(DAYS_100Y);
        s6_q100_next = '0;
        for (int k = 1; k <= Q100_MAX; k++)
        begin
            if (s5_d1_reg >= D400_W'(k) * D400_W'(DAYS_100Y) + D400_W'(1))
            begin
                s6_q100_next = 2'(k);
            end
        end
        if (s6_cent_next)
        begin
            s6_d2_next = D100_W'(s5_d1_reg - D400_W'(1)
                                 - D400_W'(s6_q100_next) * D400_W'(DAYS_100Y));
        end
        else
        begin
            s6_d2_next = D100_W'(s5_d1_reg);
        end
    end

    // Stage 7
    always_comb
    begin
        if (s6_cent_reg && (s6_d2_reg >= D100_W'(DAYS_1Y)))
        begin
            s7_d3_next = s6_d2_reg + D100_W'(1);
        end
        else
        begin
            s7_d3_next = s6_d2_reg;
        end
        s7_prod     = 32'(s7_d3_next) * 32'(RECIP_1461);
        s7_q4y_next = s7_prod[30:SHIFT_1461];
    end

    // Stage 8
    always_comb
    begin
        s8_r_next = D4_W'(s7_d3_reg - D100_W'(s7_q4y_reg) * D100_W'(DAYS_4Y));
    end

    // Stage 9
    always_comb
    begin
        s9_y1 = '0;
        for (int k = 1; k <= Q1Y_MAX; k++)
        begin
            if (s8_r_reg >= D4_W'(k) * D4_W'(DAYS_1Y) + D4_W'(1))
            begin
                s9_y1 = 2'(k);
            end
        end
        if (s9_y1 != 2'd0)
        begin
            s9_dd_next = DOY_W'(s8_r_reg - D4_W'(1) - D4_W'(s9_y1) * D4_W'(DAYS_1Y));
        end
        else
        begin
            s9_dd_next = DOY_W'(s8_r_reg);
        end
        s9_gy_next = (s8_hi_reg ? GREG_BASE_HI : GREG_BASE_LO)
                   + GY_W'(s8_q400_reg) * GY_W'(400)
                   + GY_W'(s8_q100_reg) * GY_W'(100)
                   + (GY_W'(s8_q4y_reg) << 2)
                   + GY_W'(s9_y1);
    end

    // Stage 10
    always_comb
    begin
        s10_prod     = 27'(s9_gy_reg) * 27'(RECIP_25);
        s10_q25_next = s10_prod[26:SHIFT_25];
        s10_gd_next  = s9_dd_reg + DOY_W'(1);
    end

    // Stage 11: divisible by 400 means by 16 and by 25
    always_comb
    begin
        s11_rem25 = 5'(s10_gy_reg - GY_W'(s10_q25_reg) * GY_W'(25));
        s11_leap  = ((s10_gy_reg[1:0] == 2'd0) && (s11_rem25 != 5'd0))
                 || ((s10_gy_reg[3:0] == 4'd0) && (s11_rem25 == 5'd0));
        for (int k = 0; k < 12; k++)
        begin
            s11_thr[k]   = MONTH_END[k] + DOY_W'((s11_leap && (k != 0)) ? 1 : 0);
            s11_above[k] = s10_gd_reg > s11_thr[k];
        end
        s11_cnt = 4'($countones(s11_above));
        if (s11_cnt == 4'd0)
        begin
            s11_prior = '0;
        end
        else
        begin
            s11_prior = s11_thr[s11_cnt - 4'd1];
        end
        out_month_next = s11_cnt + 4'd1;
        out_day_next   = GD_W'(s10_gd_reg - s11_prior);
    end

    // Payload registers, advanced with their stage
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s1_hi_reg <= s1_hi_next;
            s1_jy_reg <= s1_jy_next;
            s1_cm_reg <= s1_cm_next;
            s1_jd_reg <= solar.solar_day;
        end
        if (adv[1])
        begin
            s2_hi_reg  <= s1_hi_reg;
            s2_jy_reg  <= s1_jy_reg;
            s2_q33_reg <= s2_q33_next;
            s2_cm_reg  <= s1_cm_reg;
            s2_jd_reg  <= s1_jd_reg;
        end
        if (adv[2])
        begin
            s3_hi_reg  <= s2_hi_reg;
            s3_r33_reg <= s3_r33_next;
            s3_p_reg   <= s3_p_next;
        end
        if (adv[3])
        begin
            s4_hi_reg   <= s3_hi_reg;
            s4_days_reg <= s4_days_next;
        end
        if (adv[4])
        begin
            s5_hi_reg   <= s4_hi_reg;
            s5_q400_reg <= s5_q400_next;
            s5_d1_reg   <= s5_d1_next;
        end
        if (adv[5])
        begin
            s6_hi_reg   <= s5_hi_reg;
            s6_q400_reg <= s5_q400_reg;
            s6_cent_reg <= s6_cent_next;
            s6_q100_reg <= s6_q100_next;
            s6_d2_reg   <= s6_d2_next;
        end
        if (adv[6])
        begin
            s7_hi_reg   <= s6_hi_reg;
            s7_q400_reg <= s6_q400_reg;
            s7_q100_reg <= s6_q100_reg;
            s7_d3_reg   <= s7_d3_next;
            s7_q4y_reg  <= s7_q4y_next;
        end
        if (adv[7])
        begin
            s8_hi_reg   <= s7_hi_reg;
            s8_q400_reg <= s7_q400_reg;
            s8_q100_reg <= s7_q100_reg;
            s8_q4y_reg  <= s7_q4y_reg;
            s8_r_reg    <= s8_r_next;
        end
        if (adv[8])
        begin
            s9_gy_reg <= s9_gy_next;
            s9_dd_reg <= s9_dd_next;
        end
        if (adv[9])
        begin
            s10_gy_reg  <= s9_gy_reg;
            s10_q25_reg <= s10_q25_next;
            s10_gd_reg  <= s10_gd_next;
        end
        if (adv[10])
        begin
            out_year_reg  <= s10_gy_reg;
            out_month_reg <= out_month_next;
            out_day_reg   <= out_day_next;
        end
    end

endmodule

`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 100ps

module tb import jgd_pkg::*;;

    typedef struct packed {
        logic [SY_W-1:0] year;
        logic [SM_W-1:0] month;
        logic [SD_W-1:0] day;
    } solar_date_t;

    typedef struct packed {
        logic [GY_W-1:0] year;
        logic [GM_W-1:0] month;
        logic [GD_W-1:0] day;
    } greg_date_t;

    localparam int unsigned RANDOM_DATES = 1327;
    localparam int unsigned CALM_TAIL    = 150;
    localparam int unsigned PHASE_LEN    = 150;
    localparam int unsigned HOLD_AT      = 300;
    localparam int unsigned HOLD_CYCLES  = 80;
    localparam int unsigned PRINT_CAP    = 100;

    logic clk;
    logic rst_n;

    jgd_solar_if solar_ch ();
    jgd_greg_if  greg_ch ();

    jalali_to_gregorian_date u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .solar (solar_ch),
        .greg  (greg_ch)
    );

    solar_date_t dates_to_send [$];
    greg_date_t  due_dates [$];
    greg_date_t  want_date;

    int unsigned total_dates;
    int unsigned sent_count;
    int unsigned fail_count = 0;
    int unsigned send_gap;
    int unsigned take_gap;
    logic        hold_off;

    // Jalali to Gregorian conversion, same integer steps as the block
    function automatic greg_date_t convert_date(solar_date_t d);
        longint     jy;
        longint     jm;
        longint     jd;
        longint     gy;
        longint     days;
        longint     gd;
        longint     gm;
        longint     span [12];
        bit         leap;
        greg_date_t r;
        jy = longint'(d.year);
        jm = longint'(d.month);
        jd = longint'(d.day);
        if (jy > 979)
        begin
            gy = 1600;
            jy = jy - 979;
        end
        else
        begin
            gy = 621;
        end
        days = 365 * jy + (jy / 33) * 8 + ((jy % 33) + 3) / 4 + 78 + jd
             + ((jm < 7) ? (jm - 1) * 31 : (jm - 7) * 30 + 186);
        gy = gy + 400 * (days / 146097);
        days = days % 146097;
        if (days > 36524)
        begin
            days = days - 1;
            gy = gy + 100 * (days / 36524);
            days = days % 36524;
            if (days >= 365)
                days = days + 1;
        end
        gy = gy + 4 * (days / 1461);
        days = days % 1461;
        if (days > 365)
        begin
            gy = gy + (days - 1) / 365;
            days = (days - 1) % 365;
        end
        leap = ((gy % 4 == 0) && (gy % 100 != 0)) || (gy % 400 == 0);
        span = '{31, leap ? 29 : 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        // walk the months; running off the end leaves month 13
        gd = days + 1;
        gm = 13;
        for (int k = 0; k < 12; k++)
        begin
            if (gd <= span[k])
            begin
                gm = k + 1;
                break;
            end
            gd = gd - span[k];
        end
        r.year  = gy[GY_W-1:0];
        r.month = gm[GM_W-1:0];
        r.day   = gd[GD_W-1:0];
        return r;
    endfunction

    function automatic void queue_date(int unsigned y, int unsigned m, int unsigned d);
        solar_date_t s;
        s.year  = SY_W'(y);
        s.month = SM_W'(m);
        s.day   = SD_W'(d);
        dates_to_send.push_back(s);
    endfunction

    function automatic bit idling_allowed(int unsigned sent);
        if (sent + CALM_TAIL >= total_dates)
            return 1'b0;
        return ((sent / PHASE_LEN) % 3) != 0;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        if (fail_count < PRINT_CAP)
            $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #500000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Long receiver stall once the pipeline is busy; the sender keeps offering
    initial
    begin
        hold_off = 1'b0;
        while (sent_count < HOLD_AT)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        solar_date_t probe;
        greg_date_t  probe_out;
        int unsigned found;
        rst_n = 1'b0;

        // field extremes, rebase boundary, unchecked month and day values
        queue_date(1, 1, 1);
        queue_date(0, 0, 0);
        queue_date(4095, 15, 31);
        queue_date(3999, 12, 31);
        queue_date(979, 1, 1);
        queue_date(979, 12, 29);
        queue_date(979, 12, 30);
        queue_date(980, 1, 1);
        queue_date(1402, 1, 1);
        queue_date(1402, 6, 31);
        queue_date(1402, 7, 1);
        queue_date(1402, 12, 29);
        queue_date(1403, 12, 30);
        queue_date(1, 12, 31);
        queue_date(2000, 15, 31);
        queue_date(500, 13, 1);
        queue_date(1200, 0, 0);
        queue_date(1234, 14, 17);
        queue_date(4095, 0, 31);
        queue_date(2730, 10, 10);

        // day number past the end of the Gregorian year: result month 13
        found = 0;
        for (int n = 0; n < 200000 && found < 3; n++)
        begin
            probe.year  = SY_W'($urandom_range(1, 3999));
            probe.month = SM_W'($urandom_range(10, 15));
            probe.day   = SD_W'($urandom());
            probe_out   = convert_date(probe);
            if (probe_out.month == GM_W'(13))
            begin
                dates_to_send.push_back(probe);
                found++;
            end
        end

        for (int n = 0; n < RANDOM_DATES; n++)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                    queue_date($urandom_range(0, 4095), $urandom_range(0, 15),
                               $urandom_range(0, 31));
                2:
                    queue_date($urandom_range(970, 990), $urandom_range(1, 12),
                               $urandom_range(1, 31));
                3:
                    queue_date($urandom_range(1, 3999), 12, $urandom_range(25, 31));
                default:
                    queue_date($urandom_range(1, 3999), $urandom_range(1, 12),
                               $urandom_range(1, 31));
            endcase
        end
        total_dates = dates_to_send.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (sent_count < total_dates)
            @(posedge clk);
        while (due_dates.size() != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Sender: offer queued dates, hold a word until it is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            solar_ch.valid <= 1'b0;
            send_gap       <= 0;
            sent_count     <= 0;
        end
        else
        begin
            if (solar_ch.valid && solar_ch.ready)
            begin
                due_dates.push_back(convert_date({solar_ch.solar_year,
                                                  solar_ch.solar_month,
                                                  solar_ch.solar_day}));
                sent_count <= sent_count + 1;
            end
            if (solar_ch.valid && !solar_ch.ready)
            begin
                solar_ch.valid <= 1'b1;
            end
            else if (send_gap > 0)
            begin
                send_gap       <= send_gap - 1;
                solar_ch.valid <= 1'b0;
            end
            else if (dates_to_send.size() == 0)
            begin
                solar_ch.valid <= 1'b0;
            end
            else if (!hold_off && idling_allowed(sent_count) && $urandom_range(0, 5) == 0)
            begin
                send_gap       <= $urandom_range(0, 10);
                solar_ch.valid <= 1'b0;
            end
            else
            begin
                {solar_ch.solar_year, solar_ch.solar_month, solar_ch.solar_day}
                    <= dates_to_send.pop_front();
                solar_ch.valid <= 1'b1;
            end
        end
    end

    // Receiver: check each taken word against the oldest expected date
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            greg_ch.ready <= 1'b0;
            take_gap      <= 0;
        end
        else
        begin
            if (greg_ch.valid && greg_ch.ready)
            begin
                if (due_dates.size() == 0)
                begin
                    report_mismatch("unexpected word, year", greg_ch.greg_year, 0);
                end
                else
                begin
                    want_date = due_dates.pop_front();
                    if (greg_ch.greg_year != want_date.year)
                        report_mismatch("greg_year", greg_ch.greg_year, want_date.year);
                    if (greg_ch.greg_month != want_date.month)
                        report_mismatch("greg_month", greg_ch.greg_month, want_date.month);
                    if (greg_ch.greg_day != want_date.day)
                        report_mismatch("greg_day", greg_ch.greg_day, want_date.day);
                end
            end
            if (hold_off)
            begin
                greg_ch.ready <= 1'b0;
            end
            else if (take_gap > 0)
            begin
                take_gap      <= take_gap - 1;
                greg_ch.ready <= 1'b0;
            end
            else if (idling_allowed(sent_count) && $urandom_range(0, 5) == 0)
            begin
                take_gap      <= $urandom_range(0, 10);
                greg_ch.ready <= 1'b0;
            end
            else
            begin
                greg_ch.ready <= 1'b1;
            end
        end
    end

endmodule

[files.f]
design/jgd_pkg.sv
design/jgd_channels.sv
design/jalali_to_gregorian_date.sv
verif/tb.sv
